@@ rtl/vfcm_pkg.sv @@
`timescale 1ns / 1ps
package vfcm_pkg;

	localparam int CHUNK_SIZE_DEF   = 16;
	localparam int CHUNK_HEIGHT_DEF = 256;

	localparam int TYPE_W = 8;
	localparam int CFG_W  = 16;
	localparam int POS_W  = 22;
	localparam int Y_W    = 10;
	localparam int CW     = 11;	// signed neighbor coordinate
	localparam int NFACE  = 6;
	localparam int NVERT  = 6;
	localparam int NSLOT  = NFACE + 1;

	typedef enum logic [1:0] {
		CMD_SET  = 2'd0,
		CMD_READ = 2'd1,
		CMD_MESH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_CHUNK_X = 2'd0,
		CFG_CHUNK_Z = 2'd1,
		CFG_AIR     = 2'd2,
		CFG_WATER   = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_RD_DATA,
		ST_GATHER,
		ST_WAIT,
		ST_EVAL,
		ST_EMIT
	} state_t;

	// read slots: block itself, then one per face
	localparam logic [2:0] SLOT_SELF  = 3'd0;
	localparam logic [2:0] SLOT_UP    = 3'd1;
	localparam logic [2:0] SLOT_DOWN  = 3'd2;
	localparam logic [2:0] SLOT_FRONT = 3'd3;
	localparam logic [2:0] SLOT_BACK  = 3'd4;
	localparam logic [2:0] SLOT_LEFT  = 3'd5;
	localparam logic [2:0] SLOT_RIGHT = 3'd6;

	localparam logic [2:0] LAST_VERT = 3'(NVERT - 1);

	typedef struct packed {
		logic [TYPE_W-1:0] air;
		logic [TYPE_W-1:0] water;
	} codes_t;

	// corner sign bits: 1 means +half, 0 means -half
	typedef struct packed {
		logic px;
		logic py;
		logic pz;
		logic u;
		logic v;
	} corner_t;

	typedef struct packed {
		logic       found;
		logic [2:0] idx;
	} pick_t;

	localparam corner_t CORNER_TAB [NFACE][NVERT] = '{
		'{5'b01100, 5'b11110, 5'b11011, 5'b01100, 5'b11011, 5'b01001},
		'{5'b00101, 5'b00000, 5'b10010, 5'b00101, 5'b10010, 5'b10111},
		'{5'b00100, 5'b10110, 5'b11111, 5'b00100, 5'b11111, 5'b01101},
		'{5'b10000, 5'b00010, 5'b01011, 5'b10000, 5'b01011, 5'b11001},
		'{5'b00000, 5'b00110, 5'b01111, 5'b00000, 5'b01111, 5'b01001},
		'{5'b10100, 5'b10010, 5'b11011, 5'b10100, 5'b11011, 5'b11101}
	};

	function automatic pick_t lowest_set(input logic [NFACE-1:0] mask);
		pick_t p;
		p = '0;
		for (int i = NFACE - 1; i >= 0; i--) begin
			if (mask[i]) begin
				p.found = 1'b1;
				p.idx   = 3'(i);
			end
		end
		return p;
	endfunction

	function automatic logic [NFACE-1:0] above(input logic [2:0] face);
		logic [NFACE-1:0] m;
		for (int i = 0; i < NFACE; i++) begin
			m[i] = 3'(i) > face;
		end
		return m;
	endfunction

endpackage

@@ rtl/vfcm_ram.sv @@
`timescale 1ns / 1ps
module vfcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/vfcm_cull.sv @@
`timescale 1ns / 1ps
module vfcm_cull (
	input  vfcm_pkg::codes_t                codes,
	input  logic [vfcm_pkg::TYPE_W-1:0]     self_type,
	input  logic [vfcm_pkg::TYPE_W-1:0]     nb [vfcm_pkg::NFACE],
	output logic [vfcm_pkg::NFACE-1:0]      draw
);

	logic                        self_solid;
	logic                        self_water;
	logic [vfcm_pkg::NFACE-1:0]  nb_air;
	logic [vfcm_pkg::NFACE-1:0]  nb_water;
	logic [vfcm_pkg::NFACE-1:0]  nb_solid;

	always_comb begin
		self_solid = (self_type != codes.air) && (self_type != codes.water);
		self_water = self_type == codes.water;
		for (int f = 0; f < vfcm_pkg::NFACE; f++) begin
			nb_air[f]   = nb[f] == codes.air;
			nb_water[f] = nb[f] == codes.water;
			nb_solid[f] = !nb_air[f] && !nb_water[f];
			draw[f] = nb_air[f]
				|| (self_solid && nb_solid[f] && (self_type != nb[f]))
				|| (self_solid && nb_water[f])
				|| (self_water && nb_solid[f]);
		end
	end

endmodule

@@ rtl/voxel_face_cull_mesher_core.sv @@
`timescale 1ns / 1ps
// set_block: busy while ST_WRITE writes the store. read_block: result registered from ST_RD_DATA, after ST_READ.
// mesh_block: 7 store reads (one port, one per cycle), then one vertex word per cycle;
//   ST_WAIT and ST_EVAL come before the first vertex word; up to 36 words, six per drawn face.
// Results cannot be stalled; the next command is taken while the last word is on the outputs.
// Reset: the store is cleared to zero, one entry per cycle, over all CHUNK_SIZE*CHUNK_HEIGHT*CHUNK_SIZE
//   entries (65536 by default) with busy high; register writes are taken throughout.
module voxel_face_cull_mesher_core #(
	parameter int CHUNK_SIZE   = vfcm_pkg::CHUNK_SIZE_DEF,
	parameter int CHUNK_HEIGHT = vfcm_pkg::CHUNK_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [3:0]         block_x,
	input  logic [7:0]         block_y,
	input  logic [3:0]         block_z,
	input  logic [7:0]         block_type,
	input  logic [7:0]         outside_up,
	input  logic [7:0]         outside_down,
	input  logic [7:0]         outside_front,
	input  logic [7:0]         outside_back,
	input  logic [7:0]         outside_left,
	input  logic [7:0]         outside_right,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               result_valid,
	output logic signed [21:0] vertex_x2,
	output logic signed [9:0]  vertex_y2,
	output logic signed [21:0] vertex_z2,
	output logic               tex_u,
	output logic               tex_v,
	output logic [2:0]         face_index,
	output logic [7:0]         type_out,
	output logic               last
);

	localparam int DEPTH = CHUNK_SIZE * CHUNK_HEIGHT * CHUNK_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = vfcm_pkg::CW;
	localparam int TW    = vfcm_pkg::TYPE_W;
	localparam int PW    = vfcm_pkg::POS_W;
	localparam int YW    = vfcm_pkg::Y_W;
	localparam int NF    = vfcm_pkg::NFACE;

	vfcm_pkg::state_t state_q, state_d;

	logic signed [15:0] chunk_x_q, chunk_z_q;
	logic [TW-1:0]      air_q, water_q;

	logic [3:0]    bx_q, bz_q;
	logic [7:0]    by_q;
	logic [TW-1:0] type_q;
	logic [TW-1:0] outside_q [NF];
	logic          inside_q;

	logic [2:0]    rd_idx_q;
	logic          rd_vld_s1;
	logic [2:0]    rd_idx_s1;
	logic          inb_s1;
	logic [TW-1:0] nb_q [vfcm_pkg::NSLOT];
	logic [TW-1:0] nb_face [NF];

	logic [AW-1:0] clr_q;
	logic [NF-1:0] mask_q;
	logic [2:0]    face_q;
	logic [2:0]    vert_q;
	logic [PW-1:0] wx2_q, wz2_q;
	logic [YW-1:0] wy2_q;

	logic               result_valid_q;
	logic signed [PW-1:0] vx_q, vz_q;
	logic signed [YW-1:0] vy_q;
	logic               u_q, v_q, last_q;
	logic [2:0]         face_out_q;
	logic [TW-1:0]      type_out_q;

	logic          accept;
	logic          in_inside;
	logic signed [CW-1:0] sel_x, sel_y, sel_z;
	logic          sel_inb;
	logic [31:0]   lin_addr;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [TW-1:0] ram_wdata, ram_rdata;
	logic [NF-1:0] draw;
	vfcm_pkg::pick_t first_face, next_face;
	vfcm_pkg::corner_t corner;
	vfcm_pkg::codes_t codes;
	logic [PW-1:0] cx_ext, cz_ext, base_x, base_z;
	logic          emit_last;

	assign busy   = state_q != vfcm_pkg::ST_IDLE;
	assign accept = start && !busy;

	assign in_inside = (32'(block_x) < 32'(CHUNK_SIZE)) && (32'(block_y) < 32'(CHUNK_HEIGHT))
		&& (32'(block_z) < 32'(CHUNK_SIZE));

	// coordinates of the entry addressed by the current read slot
	always_comb begin
		sel_x = CW'(bx_q);
		sel_y = CW'(by_q);
		sel_z = CW'(bz_q);
		unique case (rd_idx_q)
			vfcm_pkg::SLOT_UP:    sel_y = sel_y + CW'(1);
			vfcm_pkg::SLOT_DOWN:  sel_y = sel_y - CW'(1);
			vfcm_pkg::SLOT_FRONT: sel_z = sel_z + CW'(1);
			vfcm_pkg::SLOT_BACK:  sel_z = sel_z - CW'(1);
			vfcm_pkg::SLOT_LEFT:  sel_x = sel_x - CW'(1);
			vfcm_pkg::SLOT_RIGHT: sel_x = sel_x + CW'(1);
			default: ;
		endcase
		sel_inb = (sel_x >= 0) && (sel_x < CW'(CHUNK_SIZE))
			&& (sel_y >= 0) && (sel_y < CW'(CHUNK_HEIGHT))
			&& (sel_z >= 0) && (sel_z < CW'(CHUNK_SIZE));
		lin_addr = (32'(sel_x) * 32'(CHUNK_HEIGHT) + 32'(sel_y)) * 32'(CHUNK_SIZE)
			+ 32'(sel_z);
	end

	always_comb begin
		ram_we    = (state_q == vfcm_pkg::ST_CLEAR) || (state_q == vfcm_pkg::ST_WRITE);
		ram_addr  = (state_q == vfcm_pkg::ST_CLEAR) ? clr_q : lin_addr[AW-1:0];
		ram_wdata = (state_q == vfcm_pkg::ST_CLEAR) ? '0 : type_q;
	end

	vfcm_ram #(
		.WIDTH (TW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign codes.air   = air_q;
	assign codes.water = water_q;

	always_comb begin
		for (int f = 0; f < NF; f++) begin
			nb_face[f] = nb_q[f + 1];
		end
	end

	vfcm_cull u_cull (
		.codes     (codes),
		.self_type (nb_q[vfcm_pkg::SLOT_SELF]),
		.nb        (nb_face),
		.draw      (draw)
	);

	assign first_face = vfcm_pkg::lowest_set(draw);
	assign next_face  = vfcm_pkg::lowest_set(mask_q & vfcm_pkg::above(face_q));
	assign emit_last  = (vert_q == vfcm_pkg::LAST_VERT) && !next_face.found;
	assign corner     = vfcm_pkg::CORNER_TAB[face_q][vert_q];

	assign cx_ext = PW'(chunk_x_q);
	assign cz_ext = PW'(chunk_z_q);
	assign base_x = cx_ext * PW'(CHUNK_SIZE) + PW'(bx_q);
	assign base_z = cz_ext * PW'(CHUNK_SIZE) + PW'(bz_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vfcm_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = vfcm_pkg::ST_IDLE;
				end
			end
			vfcm_pkg::ST_IDLE: begin
				if (start) begin
					unique case (vfcm_pkg::cmd_t'(command))
						vfcm_pkg::CMD_SET:
							state_d = in_inside ? vfcm_pkg::ST_WRITE : vfcm_pkg::ST_IDLE;
						vfcm_pkg::CMD_READ:
							state_d = vfcm_pkg::ST_READ;
						vfcm_pkg::CMD_MESH:
							state_d = in_inside ? vfcm_pkg::ST_GATHER : vfcm_pkg::ST_IDLE;
						default:
							state_d = vfcm_pkg::ST_IDLE;
					endcase
				end
			end
			vfcm_pkg::ST_WRITE:   state_d = vfcm_pkg::ST_IDLE;
			vfcm_pkg::ST_READ:    state_d = vfcm_pkg::ST_RD_DATA;
			vfcm_pkg::ST_RD_DATA: state_d = vfcm_pkg::ST_IDLE;
			vfcm_pkg::ST_GATHER: begin
				if (rd_idx_q == vfcm_pkg::SLOT_RIGHT) begin
					state_d = vfcm_pkg::ST_WAIT;
				end
			end
			vfcm_pkg::ST_WAIT:    state_d = vfcm_pkg::ST_EVAL;
			vfcm_pkg::ST_EVAL: begin
				if ((nb_q[vfcm_pkg::SLOT_SELF] == air_q) || !first_face.found) begin
					state_d = vfcm_pkg::ST_IDLE;
				end else begin
					state_d = vfcm_pkg::ST_EMIT;
				end
			end
			vfcm_pkg::ST_EMIT: begin
				if (emit_last) begin
					state_d = vfcm_pkg::ST_IDLE;
				end
			end
			default: state_d = vfcm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfcm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_x_q      <= '0;
			chunk_z_q      <= '0;
			air_q          <= TW'(0);
			water_q        <= TW'(1);
			clr_q          <= '0;
			rd_idx_q       <= vfcm_pkg::SLOT_SELF;
			rd_vld_s1      <= 1'b0;
			rd_idx_s1      <= vfcm_pkg::SLOT_SELF;
			mask_q         <= '0;
			face_q         <= '0;
			vert_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (vfcm_pkg::cfg_idx_t'(cfg_index))
					vfcm_pkg::CFG_CHUNK_X: chunk_x_q <= cfg_data;
					vfcm_pkg::CFG_CHUNK_Z: chunk_z_q <= cfg_data;
					vfcm_pkg::CFG_AIR:     air_q     <= cfg_data[TW-1:0];
					vfcm_pkg::CFG_WATER:   water_q   <= cfg_data[TW-1:0];
					default: ;
				endcase
			end
			if (state_q == vfcm_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == vfcm_pkg::ST_GATHER) begin
				rd_idx_q <= rd_idx_q + 3'd1;
			end else begin
				rd_idx_q <= vfcm_pkg::SLOT_SELF;
			end
			rd_vld_s1 <= state_q == vfcm_pkg::ST_GATHER;
			rd_idx_s1 <= rd_idx_q;
			if (state_q == vfcm_pkg::ST_EVAL) begin
				mask_q <= draw;
				face_q <= first_face.idx;
				vert_q <= '0;
			end else if (state_q == vfcm_pkg::ST_EMIT) begin
				if (vert_q == vfcm_pkg::LAST_VERT) begin
					vert_q <= '0;
					face_q <= next_face.idx;
				end else begin
					vert_q <= vert_q + 3'd1;
				end
			end
			result_valid_q <= (state_q == vfcm_pkg::ST_RD_DATA)
				|| (state_q == vfcm_pkg::ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bx_q         <= block_x;
			by_q         <= block_y;
			bz_q         <= block_z;
			type_q       <= block_type;
			inside_q     <= in_inside;
			outside_q[0] <= outside_up;
			outside_q[1] <= outside_down;
			outside_q[2] <= outside_front;
			outside_q[3] <= outside_back;
			outside_q[4] <= outside_left;
			outside_q[5] <= outside_right;
		end
		inb_s1 <= sel_inb;
		if (rd_vld_s1) begin
			nb_q[rd_idx_s1] <= inb_s1 ? ram_rdata : outside_q[rd_idx_s1 - 3'd1];
		end
		if (state_q == vfcm_pkg::ST_EVAL) begin
			wx2_q <= {base_x[PW-2:0], 1'b0};
			wz2_q <= {base_z[PW-2:0], 1'b0};
			wy2_q <= {1'b0, by_q, 1'b0};
		end
		if (state_q == vfcm_pkg::ST_RD_DATA) begin
			vx_q       <= '0;
			vy_q       <= '0;
			vz_q       <= '0;
			u_q        <= 1'b0;
			v_q        <= 1'b0;
			face_out_q <= '0;
			type_out_q <= inside_q ? ram_rdata : air_q;
			last_q     <= 1'b1;
		end else if (state_q == vfcm_pkg::ST_EMIT) begin
			vx_q       <= $signed(wx2_q + (corner.px ? PW'(1) : '1));
			vy_q       <= $signed(wy2_q + (corner.py ? YW'(1) : '1));
			vz_q       <= $signed(wz2_q + (corner.pz ? PW'(1) : '1));
			u_q        <= corner.u;
			v_q        <= corner.v;
			face_out_q <= face_q;
			type_out_q <= nb_q[vfcm_pkg::SLOT_SELF];
			last_q     <= emit_last;
		end
	end

	assign result_valid = result_valid_q;
	assign vertex_x2    = vx_q;
	assign vertex_y2    = vy_q;
	assign vertex_z2    = vz_q;
	assign tex_u        = u_q;
	assign tex_v        = v_q;
	assign face_index   = face_out_q;
	assign type_out     = type_out_q;
	assign last         = last_q;

	a_word_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result word without a command in progress");

	a_emit_drawn_face: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vfcm_pkg::ST_EMIT |-> mask_q[face_q] && (vert_q <= vfcm_pkg::LAST_VERT))
		else $error("emitting a face that was culled");

	a_store_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == vfcm_pkg::ST_CLEAR) || (state_q == vfcm_pkg::ST_WRITE))
		else $error("store written outside clear or set");

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result word after last");

endmodule

@@ dv/mesh_word_checker.sv @@
`timescale 1ns / 1ps
module mesh_word_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         command,
	input  logic [3:0]         block_x,
	input  logic [7:0]         block_y,
	input  logic [3:0]         block_z,
	input  logic [7:0]         block_type,
	input  logic [7:0]         outside_up,
	input  logic [7:0]         outside_down,
	input  logic [7:0]         outside_front,
	input  logic [7:0]         outside_back,
	input  logic [7:0]         outside_left,
	input  logic [7:0]         outside_right,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               result_valid,
	input  logic signed [21:0] vertex_x2,
	input  logic signed [9:0]  vertex_y2,
	input  logic signed [21:0] vertex_z2,
	input  logic               tex_u,
	input  logic               tex_v,
	input  logic [2:0]         face_index,
	input  logic [7:0]         type_out,
	input  logic               last,
	input  logic               done,
	output int                 fail_count,
	output int                 pending
);

	localparam int XZ_MAX = vfcm_pkg::CHUNK_SIZE_DEF - 1;
	localparam int Y_MAX  = vfcm_pkg::CHUNK_HEIGHT_DEF - 1;

	typedef struct packed {
		logic [21:0] x2;
		logic [9:0]  y2;
		logic [21:0] z2;
		logic        u;
		logic        v;
		logic [2:0]  face;
		logic [7:0]  kind;
		logic        last;
	} vertex_word_t;

	// px py pz u v per corner, six corners per face: top bottom front back left right
	localparam logic [0:35][4:0] CORNERS = {
		5'b01100, 5'b11110, 5'b11011, 5'b01100, 5'b11011, 5'b01001,
		5'b00101, 5'b00000, 5'b10010, 5'b00101, 5'b10010, 5'b10111,
		5'b00100, 5'b10110, 5'b11111, 5'b00100, 5'b11111, 5'b01101,
		5'b10000, 5'b00010, 5'b01011, 5'b10000, 5'b01011, 5'b11001,
		5'b00000, 5'b00110, 5'b01111, 5'b00000, 5'b01111, 5'b01001,
		5'b10100, 5'b10010, 5'b11011, 5'b10100, 5'b11011, 5'b11101
	};

	bit [7:0]           blocks [0:XZ_MAX][0:Y_MAX][0:XZ_MAX];
	logic signed [15:0] chunk_x;
	logic signed [15:0] chunk_z;
	logic [7:0]         air_code;
	logic [7:0]         water_code;
	vertex_word_t       words_due [$];
	vertex_word_t       seen;
	vertex_word_t       want;
	int                 mismatches = 0;

	function automatic bit solid(input logic [7:0] t);
		return t != air_code && t != water_code;
	endfunction

	function automatic bit face_shown(input logic [7:0] self, input logic [7:0] nb);
		if (nb == air_code)
			return 1'b1;
		if (solid(self) && solid(nb))
			return self != nb;
		if (solid(self) && nb == water_code)
			return 1'b1;
		return self == water_code && solid(nb);
	endfunction

	task automatic report(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic expect_word(input vertex_word_t w);
		words_due = {words_due, w};
	endtask

	task automatic mesh_block(input logic [3:0] bx, input logic [7:0] by,
		input logic [3:0] bz, input logic [5:0][7:0] outside);
		vertex_word_t batch [36];
		logic [7:0]   self;
		logic [7:0]   nb;
		logic [4:0]   c;
		int           wx2, wy2, wz2, nx, ny, nz, n;
		n = 0;
		self = blocks[bx][by][bz];
		if (self == air_code)
			return;
		wx2 = 2 * (int'(chunk_x) * vfcm_pkg::CHUNK_SIZE_DEF + int'(bx));
		wy2 = 2 * int'(by);
		wz2 = 2 * (int'(chunk_z) * vfcm_pkg::CHUNK_SIZE_DEF + int'(bz));
		for (int f = 0; f < 6; f++) begin
			nx = int'(bx);
			ny = int'(by);
			nz = int'(bz);
			case (f)
				0: ny++;
				1: ny--;
				2: nz++;
				3: nz--;
				4: nx--;
				default: nx++;
			endcase
			if (nx < 0 || nx > XZ_MAX || ny < 0 || ny > Y_MAX || nz < 0 || nz > XZ_MAX)
				nb = outside[f];
			else
				nb = blocks[nx][ny][nz];
			if (!face_shown(self, nb))
				continue;
			for (int i = 0; i < 6; i++) begin
				c = CORNERS[f * 6 + i];
				batch[n].x2   = 22'(wx2 + (c[4] ? 1 : -1));
				batch[n].y2   = 10'(wy2 + (c[3] ? 1 : -1));
				batch[n].z2   = 22'(wz2 + (c[2] ? 1 : -1));
				batch[n].u    = c[1];
				batch[n].v    = c[0];
				batch[n].face = 3'(f);
				batch[n].kind = self;
				batch[n].last = 1'b0;
				n++;
			end
		end
		if (n > 0)
			batch[n - 1].last = 1'b1;
		for (int k = 0; k < n; k++)
			expect_word(batch[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_x    <= '0;
			chunk_z    <= '0;
			air_code   <= '0;
			water_code <= 8'd1;
			pending    <= 0;
			fail_count <= mismatches;
		end else begin
			if (result_valid) begin
				seen = {vertex_x2, vertex_y2, vertex_z2, tex_u, tex_v, face_index, type_out, last};
				if (words_due.size() == 0) begin
					report($sformatf("unexpected word: face %0d type %0d last %b",
						face_index, type_out, last));
				end else begin
					want = words_due.pop_front();
					if (seen !== want)
						report($sformatf({"got x2 %0d y2 %0d z2 %0d uv %b%b face %0d type %0d",
							" last %b, want x2 %0d y2 %0d z2 %0d uv %b%b face %0d type %0d last %b"},
							$signed(seen.x2), $signed(seen.y2), $signed(seen.z2), seen.u, seen.v,
							seen.face, seen.kind, seen.last,
							$signed(want.x2), $signed(want.y2), $signed(want.z2), want.u, want.v,
							want.face, want.kind, want.last));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					vfcm_pkg::CFG_CHUNK_X: chunk_x    <= cfg_data;
					vfcm_pkg::CFG_CHUNK_Z: chunk_z    <= cfg_data;
					vfcm_pkg::CFG_AIR:     air_code   <= cfg_data[7:0];
					vfcm_pkg::CFG_WATER:   water_code <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (command)
					vfcm_pkg::CMD_SET: blocks[block_x][block_y][block_z] = block_type;
					vfcm_pkg::CMD_READ: begin
						want      = '0;
						want.kind = blocks[block_x][block_y][block_z];
						want.last = 1'b1;
						expect_word(want);
					end
					vfcm_pkg::CMD_MESH: mesh_block(block_x, block_y, block_z,
						{outside_right, outside_left, outside_back, outside_front,
						outside_down, outside_up});
					default: ;
				endcase
			end
			if (done && words_due.size() != 0) begin
				report($sformatf("%0d words never arrived", words_due.size()));
				words_due.delete();
			end
			pending    <= words_due.size();
			fail_count <= mismatches;
		end
	end

endmodule

@@ dv/voxel_face_cull_mesher_core_test.sv @@
`timescale 1ns / 1ps
module voxel_face_cull_mesher_core_test;

	localparam int         CYCLE_LIMIT = 400000;
	localparam int         XZ_MAX      = vfcm_pkg::CHUNK_SIZE_DEF - 1;
	localparam int         Y_MAX       = vfcm_pkg::CHUNK_HEIGHT_DEF - 1;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               start         = 1'b0;
	logic               busy;
	logic [1:0]         command       = vfcm_pkg::CMD_SET;
	logic [3:0]         block_x       = '0;
	logic [7:0]         block_y       = '0;
	logic [3:0]         block_z       = '0;
	logic [7:0]         block_type    = '0;
	logic [7:0]         outside_up    = '0;
	logic [7:0]         outside_down  = '0;
	logic [7:0]         outside_front = '0;
	logic [7:0]         outside_back  = '0;
	logic [7:0]         outside_left  = '0;
	logic [7:0]         outside_right = '0;
	logic               cfg_we        = 1'b0;
	logic [1:0]         cfg_index     = vfcm_pkg::CFG_CHUNK_X;
	logic [15:0]        cfg_data      = '0;
	logic               result_valid;
	logic signed [21:0] vertex_x2;
	logic signed [9:0]  vertex_y2;
	logic signed [21:0] vertex_z2;
	logic               tex_u;
	logic               tex_v;
	logic [2:0]         face_index;
	logic [7:0]         type_out;
	logic               last;
	logic               done          = 1'b0;
	int                 fail_count;
	int                 pending;

	int         cycles    = 0;
	int         issued    = 0;
	int         gap_max   = 0;
	logic [7:0] cur_air   = 8'd0;
	logic [7:0] cur_water = 8'd1;
	logic [3:0] cx;
	logic [7:0] cy;
	logic [3:0] cz;

	voxel_face_cull_mesher_core dut (.*);

	mesh_word_checker word_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// {right, left, back, front, down, up}
	function automatic logic [5:0][7:0] outs6(input logic [7:0] u, input logic [7:0] d,
		input logic [7:0] f, input logic [7:0] b, input logic [7:0] l, input logic [7:0] r);
		return {r, l, b, f, d, u};
	endfunction

	function automatic logic [7:0] pick_type();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return cur_air;
		if (r < 40)
			return cur_water;
		if (r < 85)
			return 8'(20 + $urandom_range(0, 2));
		return 8'($urandom);
	endfunction

	function automatic logic [5:0][7:0] random_outs();
		return {pick_type(), pick_type(), pick_type(), pick_type(), pick_type(), pick_type()};
	endfunction

	task automatic issue(input logic [1:0] op, input logic [3:0] x, input logic [7:0] y,
		input logic [3:0] z, input logic [7:0] kind, input logic [5:0][7:0] outs);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		command       <= op;
		block_x       <= x;
		block_y       <= y;
		block_z       <= z;
		block_type    <= kind;
		outside_up    <= outs[0];
		outside_down  <= outs[1];
		outside_front <= outs[2];
		outside_back  <= outs[3];
		outside_left  <= outs[4];
		outside_right <= outs[5];
		do @(posedge clk); while (busy);
		if (op != CMD_UNUSED)
			issued++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// a mesh that draws nothing still keeps the block busy a while
		repeat (16) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] chx, input logic [15:0] chz,
		input logic [7:0] air, input logic [7:0] water);
		cfg_we    <= 1'b1;
		cfg_index <= vfcm_pkg::CFG_CHUNK_X;
		cfg_data  <= chx;
		@(posedge clk);
		cfg_index <= vfcm_pkg::CFG_CHUNK_Z;
		cfg_data  <= chz;
		@(posedge clk);
		cfg_index <= vfcm_pkg::CFG_AIR;
		cfg_data  <= {8'($urandom), air};
		@(posedge clk);
		cfg_index <= vfcm_pkg::CFG_WATER;
		cfg_data  <= {8'($urandom), water};
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_air   = air;
		cur_water = water;
	endtask

	task automatic pick_near(output logic [3:0] x, output logic [7:0] y, output logic [3:0] z);
		int ix, iy, iz;
		ix = int'(cx);
		iy = int'(cy);
		iz = int'(cz);
		case ($urandom_range(0, 6))
			0: iy++;
			1: iy--;
			2: iz++;
			3: iz--;
			4: ix--;
			5: ix++;
			default: ;
		endcase
		if (ix < 0 || ix > XZ_MAX || iy < 0 || iy > Y_MAX || iz < 0 || iz > XZ_MAX) begin
			ix = int'(cx);
			iy = int'(cy);
			iz = int'(cz);
		end
		x = 4'(ix);
		y = 8'(iy);
		z = 4'(iz);
	endtask

	// build around one block, mesh it, read back nearby, sometimes a stray word
	task automatic mesh_burst();
		logic [3:0] x, z;
		logic [7:0] y, kind;
		gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
		case ($urandom_range(0, 4))
			0: cx = '0;
			1: cx = 4'(XZ_MAX);
			default: cx = 4'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0: cz = '0;
			1: cz = 4'(XZ_MAX);
			default: cz = 4'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: cy = '0;
			1: cy = 8'(Y_MAX);
			2: cy = 8'($urandom);
			default: cy = 8'($urandom_range(1, 6));
		endcase
		if ($urandom_range(0, 9) == 0)
			kind = pick_type();
		else if ($urandom_range(0, 3) == 0)
			kind = cur_water;
		else
			kind = 8'(20 + $urandom_range(0, 2));
		issue(vfcm_pkg::CMD_SET, cx, cy, cz, kind, random_outs());
		repeat ($urandom_range(0, 6)) begin
			pick_near(x, y, z);
			issue(vfcm_pkg::CMD_SET, x, y, z, pick_type(), random_outs());
		end
		issue(vfcm_pkg::CMD_MESH, cx, cy, cz, 8'($urandom), random_outs());
		if ($urandom_range(0, 1) == 1) begin
			pick_near(x, y, z);
			issue(vfcm_pkg::CMD_READ, x, y, z, 8'($urandom), random_outs());
		end
		if ($urandom_range(0, 5) == 0)
			issue(2'($urandom), 4'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
				48'({$urandom, $urandom}));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		program_regs(16'h0000, 16'h0000, 8'd0, 8'd1);

		gap_max = 3;
		issue(vfcm_pkg::CMD_READ, 4'd0, 8'd0, 4'd0, 8'd0, '0);
		issue(vfcm_pkg::CMD_MESH, 4'd0, 8'd0, 4'd0, 8'd0, '0);
		issue(CMD_UNUSED, 4'hf, 8'hff, 4'hf, 8'hff, '1);
		issue(vfcm_pkg::CMD_SET, 4'd0, 8'd0, 4'd0, 8'd5, '0);
		issue(vfcm_pkg::CMD_MESH, 4'd0, 8'd0, 4'd0, 8'd0, '0);
		issue(vfcm_pkg::CMD_SET, 4'hf, 8'hff, 4'hf, 8'hff, '0);
		issue(vfcm_pkg::CMD_MESH, 4'hf, 8'hff, 4'hf, 8'd0,
			outs6(8'hff, 8'haa, 8'd1, 8'haa, 8'haa, 8'd7));
		issue(vfcm_pkg::CMD_SET, 4'd1, 8'd0, 4'd0, 8'd5, '0);
		issue(vfcm_pkg::CMD_MESH, 4'd0, 8'd0, 4'd0, 8'd0,
			outs6(8'd0, 8'd5, 8'd0, 8'd5, 8'd5, 8'd0));
		// water block: water above, solid below
		issue(vfcm_pkg::CMD_SET, 4'd8, 8'd100, 4'd8, 8'd1, '0);
		issue(vfcm_pkg::CMD_SET, 4'd8, 8'd101, 4'd8, 8'd1, '0);
		issue(vfcm_pkg::CMD_SET, 4'd8, 8'd99, 4'd8, 8'd9, '0);
		issue(vfcm_pkg::CMD_MESH, 4'd8, 8'd100, 4'd8, 8'd0, '0);
		// fully enclosed by the same type: nothing drawn
		issue(vfcm_pkg::CMD_SET, 4'd3, 8'd3, 4'd3, 8'd9, '0);
		issue(vfcm_pkg::CMD_SET, 4'd3, 8'd4, 4'd3, 8'd9, '0);
		issue(vfcm_pkg::CMD_SET, 4'd3, 8'd2, 4'd3, 8'd9, '0);
		issue(vfcm_pkg::CMD_SET, 4'd3, 8'd3, 4'd4, 8'd9, '0);
		issue(vfcm_pkg::CMD_SET, 4'd3, 8'd3, 4'd2, 8'd9, '0);
		issue(vfcm_pkg::CMD_SET, 4'd2, 8'd3, 4'd3, 8'd9, '0);
		issue(vfcm_pkg::CMD_SET, 4'd4, 8'd3, 4'd3, 8'd9, '0);
		issue(vfcm_pkg::CMD_MESH, 4'd3, 8'd3, 4'd3, 8'd0, '0);
		issue(vfcm_pkg::CMD_READ, 4'hf, 8'hff, 4'hf, 8'd0, '0);
		issue(vfcm_pkg::CMD_SET, 4'd0, 8'd0, 4'd0, 8'd0, '0);
		issue(vfcm_pkg::CMD_READ, 4'd0, 8'd0, 4'd0, 8'd0, '0);

		while (issued < 70) mesh_burst();
		drain();
		program_regs(16'h8000, 16'h7fff, 8'd0, 8'd1);
		while (issued < 120) mesh_burst();
		drain();
		program_regs(16'h7fff, 16'h8000, 8'hff, 8'h00);
		while (issued < 170) mesh_burst();
		drain();
		program_regs(16'($urandom), 16'($urandom), 8'd3, 8'd3);
		while (issued < 220) mesh_burst();
		drain();
		program_regs(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
		while (issued < 280) mesh_burst();
		drain();

		done <= 1'b1;
		repeat (3) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/vfcm_pkg.sv
rtl/vfcm_ram.sv
rtl/vfcm_cull.sv
rtl/voxel_face_cull_mesher_core.sv
dv/mesh_word_checker.sv
dv/voxel_face_cull_mesher_core_test.sv
